FILE: rtl/core/mxp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_pkg: shared types and constants of the maximum XOR pair trie
// Widths of values, node indexes and counters, plus the controller and
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package mxp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int NODE_COUNT = 65536;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LVL_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LINK_W     = 2 * IDX_W;

    // Child links of one trie node. A zero link means no child.
    typedef struct packed {
        logic [IDX_W-1:0] one;
        logic [IDX_W-1:0] zero;
    } links_t;

    typedef struct packed {
        logic load;
        logic q_step;
        logic q_end;
        logic i_step;
        logic alloc_div;
        logic alloc_new;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic had;
        logic lvl_zero;
        logic q_stop;
        logic i_hit;
        logic fits;
    } status_t;

endpackage

FILE: rtl/core/mxp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mxp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/mxp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_ctrl: sequencer of the maximum XOR pair trie
// Steps each item through query walk, insertion walk and node allocation,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module mxp_ctrl import mxp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_QUERY     = 3'd1;
    localparam logic [2:0] S_QEND      = 3'd2;
    localparam logic [2:0] S_IWALK     = 3'd3;
    localparam logic [2:0] S_ALLOC_DIV = 3'd4;
    localparam logic [2:0] S_ALLOC_NEW = 3'd5;
    localparam logic [2:0] S_FIN       = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = st.had ? S_QUERY : S_IWALK;
                end
            end
            S_QUERY: begin
                cmd.q_step = 1'b1;
                if (st.q_stop || st.lvl_zero) begin
                    state_next = S_QEND;
                end
            end
            S_QEND: begin
                cmd.q_end  = 1'b1;
                state_next = S_IWALK;
            end
            S_IWALK: begin
                cmd.i_step = 1'b1;
                if (st.i_hit) begin
                    if (st.lvl_zero) begin
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = st.fits ? S_ALLOC_DIV : S_FIN;
                end
            end
            S_ALLOC_DIV: begin
                cmd.alloc_div = 1'b1;
                state_next    = S_ALLOC_NEW;
            end
            S_ALLOC_NEW: begin
                cmd.alloc_new = 1'b1;
                if (st.lvl_zero) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                // The result moves to the output register once it is free.
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/mxp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_dpath: datapath of the maximum XOR pair trie
// Holds the root links, node counter, running maximum and the walk
// registers, and drives the node memory.
// ----------------------------------------------------------------------------
module mxp_dpath import mxp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_BITS-1:0] s_value,
    input  cmd_t                  cmd,
    output status_t               st,
    output logic [VALUE_BITS-1:0] m_item_best_xor,
    output logic [VALUE_BITS-1:0] m_running_best_xor,
    output logic                  m_has_pair,
    output logic                  m_pool_full
);

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [IDX_W-1:0]      node_reg, node_next;
    logic                  at_root_reg, at_root_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic                  seen_reg, seen_next;
    logic                  had_reg, had_next;
    logic                  drop_reg, drop_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    links_t                root_reg, root_next;
    links_t                div_reg, div_next;
    logic [VALUE_BITS-1:0] out_item_reg, out_item_next;
    logic [VALUE_BITS-1:0] out_best_reg, out_best_next;
    logic                  out_has_reg, out_has_next;
    logic                  out_full_reg, out_full_next;

    logic [LINK_W-1:0] ram_rdata;
    logic [LINK_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    logic              ram_we;

    links_t           cur;
    links_t           div_upd;
    links_t           new_links;
    logic             bit_cur;
    logic             bit_below;
    logic [LVL_W-1:0] lvl_m1;
    logic [IDX_W-1:0] same_l;
    logic [IDX_W-1:0] opp_l;
    logic [IDX_W-1:0] new_idx;
    logic [CNT_W-1:0] need;
    logic [CNT_W:0]   used_plus;

    // The root lives in flip-flops; every other node is read from memory
    // at the address issued by the previous walk step.
    assign cur       = at_root_reg ? root_reg : links_t'(ram_rdata);
    assign bit_cur   = value_reg[lvl_reg];
    assign lvl_m1    = lvl_reg - 1'b1;
    assign bit_below = value_reg[lvl_m1];
    assign same_l    = bit_cur ? cur.one : cur.zero;
    assign opp_l     = bit_cur ? cur.zero : cur.one;
    assign new_idx   = used_reg[IDX_W-1:0];
    assign need      = CNT_W'(lvl_reg) + 1'b1;
    assign used_plus = {1'b0, used_reg} + {1'b0, need};

    assign st.had      = seen_reg;
    assign st.lvl_zero = (lvl_reg == '0);
    assign st.q_stop   = (opp_l == '0) && (same_l == '0);
    assign st.i_hit    = (same_l != '0);
    assign st.fits     = (used_plus <= (CNT_W + 1)'(NODE_COUNT));

    always_comb begin
        div_upd = div_reg;
        if (bit_cur) begin
            div_upd.one = new_idx;
        end else begin
            div_upd.zero = new_idx;
        end
        new_links = '0;
        if (lvl_reg != '0) begin
            if (bit_below) begin
                new_links.one = new_idx + 1'b1;
            end else begin
                new_links.zero = new_idx + 1'b1;
            end
        end
    end

    always_comb begin
        ram_raddr = same_l;
        if (cmd.q_step && (opp_l != '0)) begin
            ram_raddr = opp_l;
        end
        ram_we    = cmd.alloc_new || (cmd.alloc_div && !at_root_reg);
        ram_waddr = cmd.alloc_div ? node_reg : new_idx;
        ram_wdata = cmd.alloc_div ? LINK_W'(div_upd) : LINK_W'(new_links);
    end

    always_comb begin
        value_next    = value_reg;
        lvl_next      = lvl_reg;
        node_next     = node_reg;
        at_root_next  = at_root_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        seen_next     = seen_reg;
        had_next      = had_reg;
        drop_next     = drop_reg;
        used_next     = used_reg;
        root_next     = root_reg;
        div_next      = div_reg;
        out_item_next = out_item_reg;
        out_best_next = out_best_reg;
        out_has_next  = out_has_reg;
        out_full_next = out_full_reg;

        if (cmd.load) begin
            value_next   = s_value;
            lvl_next     = LVL_TOP;
            at_root_next = 1'b1;
            acc_next     = '0;
            had_next     = seen_reg;
            drop_next    = 1'b0;
        end
        if (cmd.q_step && !st.q_stop) begin
            node_next    = ram_raddr;
            at_root_next = 1'b0;
            acc_next     = {acc_reg[VALUE_BITS-2:0], (opp_l != '0)};
            lvl_next     = lvl_m1;
        end
        if (cmd.q_end) begin
            if (acc_reg > best_reg) begin
                best_next = acc_reg;
            end
            lvl_next     = LVL_TOP;
            at_root_next = 1'b1;
        end
        if (cmd.i_step) begin
            if (st.i_hit) begin
                node_next    = same_l;
                at_root_next = 1'b0;
                lvl_next     = lvl_m1;
            end else begin
                // Keep the divergence node's links for the update write.
                div_next  = cur;
                drop_next = !st.fits;
            end
        end
        if (cmd.alloc_div && at_root_reg) begin
            root_next = div_upd;
        end
        if (cmd.alloc_new) begin
            used_next = used_reg + 1'b1;
            lvl_next  = lvl_m1;
        end
        if (cmd.finish) begin
            out_item_next = acc_reg;
            out_best_next = best_reg;
            out_has_next  = had_reg;
            out_full_next = drop_reg;
            if (!drop_reg) begin
                seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
            seen_reg <= 1'b0;
            used_reg <= CNT_W'(1);
            root_reg <= '0;
        end else begin
            best_reg <= best_next;
            seen_reg <= seen_next;
            used_reg <= used_next;
            root_reg <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        lvl_reg      <= lvl_next;
        node_reg     <= node_next;
        at_root_reg  <= at_root_next;
        acc_reg      <= acc_next;
        had_reg      <= had_next;
        drop_reg     <= drop_next;
        div_reg      <= div_next;
        out_item_reg <= out_item_next;
        out_best_reg <= out_best_next;
        out_has_reg  <= out_has_next;
        out_full_reg <= out_full_next;
    end

    assign m_item_best_xor    = out_item_reg;
    assign m_running_best_xor = out_best_reg;
    assign m_has_pair         = out_has_reg;
    assign m_pool_full        = out_full_reg;

    mxp_ram #(
        .WIDTH(LINK_W),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

FILE: rtl/core/max_xor_pair_trie_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_xor_pair_trie_top: streaming maximum XOR pair search over a binary trie
// Each value is queried against all stored values, then inserted.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid, s_ready, s_value) takes one 32-bit value per
//   beat. The result channel (m_valid, m_ready, m_*) returns one beat per
//   value: its best XOR against earlier values, the running maximum, whether
//   an earlier value existed, and whether the insertion was dropped because
//   the node pool was full.
//   One item is processed at a time. The query walk steps down the trie one
//   bit per level and then updates the running maximum; the first value
//   skips it. The insertion walk follows the levels that already exist;
//   where it meets a missing level, the divergence node's link is updated
//   and then each new node is allocated. The node memory returns one node
//   per cycle. A repeated value, or a dropped insertion, needs no allocation.
//   The next value is accepted as soon as the result is registered.
//   The result sits in an output register, so the next value is accepted
//   while an earlier result waits. A stalled receiver blocks the block only
//   when a second result is ready and the register is still occupied.
//   Reset (aresetn low, synchronous) empties the trie and clears the running
//   maximum at once; no memory sweep is needed.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_top import mxp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_item_best_xor,
    output logic [VALUE_BITS-1:0] m_running_best_xor,
    output logic                  m_has_pair,
    output logic                  m_pool_full
);

    cmd_t    cmd;
    status_t st;

    mxp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .st     (st),
        .cmd    (cmd)
    );

    mxp_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_value           (s_value),
        .cmd               (cmd),
        .st                (st),
        .m_item_best_xor   (m_item_best_xor),
        .m_running_best_xor(m_running_best_xor),
        .m_has_pair        (m_has_pair),
        .m_pool_full       (m_pool_full)
    );

endmodule
